@@ sv/monitor_interval_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// Monitor interval tracker assertion macros
// Shared concurrent assertion forms used by the tracker modules.
// ----------------------------------------------------------------------------
`ifndef MONITOR_INTERVAL_TRACKER_ASSERT_SVH
`define MONITOR_INTERVAL_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/mit_pkg.sv @@
// ----------------------------------------------------------------------------
// mit_pkg
// Types, codes and helpers shared by the monitor interval tracker.
// ----------------------------------------------------------------------------
package mit_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int OCC_W           = 5;

    // command codes of an input beat
    typedef enum logic [2:0] {
        OP_ENQ    = 3'd0,
        OP_SENT   = 3'd1,
        OP_BEGIN  = 3'd2,
        OP_LOST   = 3'd3,
        OP_ACKED  = 3'd4,
        OP_END    = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_NONE   = 3'd7
    } t_op;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_RECORD  = 3'd1,
        ST_INVALID = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // back-end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT,
        S_RESP
    } t_state;

    // classified input beat
    typedef struct packed {
        t_op          op;
        logic [39:0]  rate;
        logic         useful;
        logic [15:0]  tolerance;
        logic [31:0]  rtt_us;
        logic [47:0]  time_us;
        logic [47:0]  pkt_num;
        logic [15:0]  byte_count;
    } t_item;

    // one monitor interval
    typedef struct packed {
        logic [39:0]  rate;
        logic         useful;
        logic [15:0]  tolerance;
        logic [47:0]  first_time;
        logic [47:0]  last_time;
        logic [47:0]  first_pkt;
        logic [47:0]  last_pkt;
        logic [31:0]  sent;
        logic [31:0]  acked;
        logic [31:0]  lost;
        logic [31:0]  rtt_start;
        logic [31:0]  rtt_end;
    } t_entry;

    // one result beat
    typedef struct packed {
        t_status      status;
        logic [39:0]  rate;
        logic [15:0]  tolerance;
        logic [47:0]  first_time;
        logic [47:0]  last_time;
        logic [31:0]  sent;
        logic [31:0]  acked;
        logic [31:0]  lost;
        logic [31:0]  rtt_start;
        logic [31:0]  rtt_end;
        logic         last;
        logic [OCC_W-1:0] occupancy;
    } t_result;

    // saturating byte counter add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // acked + lost equals sent, summed without limit
    function automatic logic is_complete(input t_entry e);
        return ({1'b0, e.acked} + {1'b0, e.lost}) == {1'b0, e.sent};
    endfunction

endpackage

@@ sv/monitor_interval_tracker.sv @@
// ----------------------------------------------------------------------------
// monitor_interval_tracker
// Queue of congestion-control monitor intervals with event crediting and
// utility record output.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Enqueue, packet sent, clear and unused
// commands pass through the sequencer as an execute step, then a result beat.
// Event begin, lost, acked and end walk the queued intervals one per cycle
// through a single storage access port, then give the result beat; on an
// empty queue (or, for end, with no useful interval) they skip the walk.
// An end item that emits records walks the queue and then emits one record
// per useful interval up to the last useful one, in place of the result beat.
// Output stalls hold the result and record beats. A two-beat input queue
// keeps accepting until it is full while the sequencer works.

module monitor_interval_tracker #(
    parameter int QUEUE_DEPTH = mit_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [39:0] i_rate,
    input  logic        i_useful,
    input  logic [15:0] i_tolerance,
    input  logic [31:0] i_rtt_us,
    input  logic [47:0] i_time_us,
    input  logic [47:0] i_pkt_num,
    input  logic [15:0] i_byte_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [39:0] o_rec_rate,
    output logic [15:0] o_rec_tolerance,
    output logic [47:0] o_rec_first_time,
    output logic [47:0] o_rec_last_time,
    output logic [31:0] o_rec_sent,
    output logic [31:0] o_rec_acked,
    output logic [31:0] o_rec_lost,
    output logic [31:0] o_rec_rtt_start,
    output logic [31:0] o_rec_rtt_end,
    output logic        o_last,
    output logic [4:0]  o_occupancy
);

    logic             w_q_valid;
    logic             w_q_pop;
    mit_pkg::t_item   w_q_item;
    mit_pkg::t_result w_res;

    // intake and decode
    mit_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_rate       (i_rate),
        .i_useful     (i_useful),
        .i_tolerance  (i_tolerance),
        .i_rtt_us     (i_rtt_us),
        .i_time_us    (i_time_us),
        .i_pkt_num    (i_pkt_num),
        .i_byte_count (i_byte_count),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item),
        .i_q_pop      (w_q_pop)
    );

    // interval storage and sequencer
    mit_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_res)
    );

    assign o_status         = w_res.status;
    assign o_rec_rate       = w_res.rate;
    assign o_rec_tolerance  = w_res.tolerance;
    assign o_rec_first_time = w_res.first_time;
    assign o_rec_last_time  = w_res.last_time;
    assign o_rec_sent       = w_res.sent;
    assign o_rec_acked      = w_res.acked;
    assign o_rec_lost       = w_res.lost;
    assign o_rec_rtt_start  = w_res.rtt_start;
    assign o_rec_rtt_end    = w_res.rtt_end;
    assign o_last           = w_res.last;
    assign o_occupancy      = w_res.occupancy;

endmodule

@@ sv/mit_front.sv @@
// ----------------------------------------------------------------------------
// mit_front
// Accepts input beats, decodes the command and buffers them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mit_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_cmd,
    input  logic [39:0]         i_rate,
    input  logic                i_useful,
    input  logic [15:0]         i_tolerance,
    input  logic [31:0]         i_rtt_us,
    input  logic [47:0]         i_time_us,
    input  logic [47:0]         i_pkt_num,
    input  logic [15:0]         i_byte_count,
    output logic                o_q_valid,
    output mit_pkg::t_item      o_q_item,
    input  logic                i_q_pop
);

    mit_pkg::t_item r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    mit_pkg::t_op   w_op;
    mit_pkg::t_item w_item;
    logic           w_push;

    // command decode: every 3-bit code has an enum member
    assign w_op = mit_pkg::t_op'(i_cmd);

    always_comb begin
        w_item.op         = w_op;
        w_item.rate       = i_rate;
        w_item.useful     = i_useful;
        w_item.tolerance  = i_tolerance;
        w_item.rtt_us     = i_rtt_us;
        w_item.time_us    = i_time_us;
        w_item.pkt_num    = i_pkt_num;
        w_item.byte_count = i_byte_count;
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

endmodule

@@ sv/mit_back.sv @@
// ----------------------------------------------------------------------------
// mit_back
// Interval storage and the sequencer that walks the queue one interval
// per cycle, plus the registered result stage.
// ----------------------------------------------------------------------------
`include "monitor_interval_tracker_assert.svh"

module mit_back #(
    parameter int QUEUE_DEPTH = mit_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  mit_pkg::t_item      i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mit_pkg::t_result    o_result
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    mit_pkg::t_entry   r_ent [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_done;

    mit_pkg::t_state   r_state, n_state;
    mit_pkg::t_item    r_item, n_item;
    mit_pkg::t_status  r_status, n_status;
    logic [PW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_ucount, n_ucount;
    logic [31:0]       r_evrtt, n_evrtt;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_lastpos, n_lastpos;
    logic [CW-1:0]     r_keep, n_keep;
    logic              r_stop, n_stop;
    logic              r_notdone, n_notdone;
    mit_pkg::t_result  r_out, n_out;
    logic              r_ovalid;

    logic [CW-1:0]     w_off;
    logic [CW:0]       w_sum;
    logic [PW-1:0]     w_slot;
    logic [CW-1:0]     w_pop_lp;
    logic [CW:0]       w_psum;
    logic [PW-1:0]     w_phead;
    mit_pkg::t_entry   w_ent;
    logic              w_done;
    logic              w_we;
    mit_pkg::t_entry   w_wdata;
    logic              w_dwe;
    logic              w_dval;
    logic              w_ofree;
    logic              w_load;
    logic              w_lastit;
    logic [CW-1:0]     w_idx1;
    logic [CW+4:0]     w_occ_cnt;
    logic [CW+4:0]     w_occ_keep;

    // slot of queue position w_off
    always_comb begin
        w_sum  = (CW+1)'(r_head) + (CW+1)'(w_off);
        w_slot = (w_sum >= (CW+1)'(QUEUE_DEPTH)) ? PW'(w_sum - (CW+1)'(QUEUE_DEPTH))
                                                 : PW'(w_sum);
    end

    // head after popping w_pop_lp intervals
    always_comb begin
        w_psum  = (CW+1)'(r_head) + (CW+1)'(w_pop_lp);
        w_phead = (w_psum >= (CW+1)'(QUEUE_DEPTH)) ? PW'(w_psum - (CW+1)'(QUEUE_DEPTH))
                                                   : PW'(w_psum);
    end

    assign w_ent      = r_ent[w_slot];
    assign w_done     = r_done[w_slot];
    assign w_ofree    = !r_ovalid || !i_out_stall;
    assign w_idx1     = r_idx + CW'(1);
    assign w_lastit   = (w_idx1 == r_count);
    assign w_occ_cnt  = (CW+5)'(r_count);
    assign w_occ_keep = (CW+5)'(r_keep);

    // sequencer: next state and datapath controls
    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_status  = r_status;
        n_head    = r_head;
        n_count   = r_count;
        n_ucount  = r_ucount;
        n_evrtt   = r_evrtt;
        n_idx     = r_idx;
        n_lastpos = r_lastpos;
        n_keep    = r_keep;
        n_stop    = r_stop;
        n_notdone = r_notdone;
        n_out     = r_out;
        w_load    = 1'b0;
        w_off     = r_idx;
        w_pop_lp  = r_lastpos;
        w_we      = 1'b0;
        w_wdata   = w_ent;
        w_dwe     = 1'b0;
        w_dval    = 1'b0;
        o_q_pop   = 1'b0;

        unique case (r_state)
            mit_pkg::S_IDLE: begin
                n_idx     = '0;
                n_stop    = 1'b0;
                n_notdone = 1'b0;
                n_lastpos = '0;
                n_status  = mit_pkg::ST_OK;
                n_item    = i_q_item;
                w_off     = (i_q_item.op == mit_pkg::OP_SENT) ? r_count - CW'(1) : r_count;
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = mit_pkg::S_RESP;
                    unique case (i_q_item.op)
                        mit_pkg::OP_ENQ: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_status = mit_pkg::ST_FULL;
                            end else begin
                                w_we              = 1'b1;
                                w_wdata           = '0;
                                w_wdata.rate      = i_q_item.rate;
                                w_wdata.useful    = i_q_item.useful;
                                w_wdata.tolerance = i_q_item.tolerance;
                                w_wdata.rtt_start = i_q_item.rtt_us;
                                w_wdata.rtt_end   = i_q_item.rtt_us;
                                w_dwe             = 1'b1;
                                w_dval            = 1'b0;
                                n_count           = r_count + CW'(1);
                                n_ucount          = r_ucount + CW'(i_q_item.useful);
                            end
                        end
                        mit_pkg::OP_SENT: begin
                            if (r_count == '0) begin
                                n_status = mit_pkg::ST_EMPTY;
                            end else begin
                                w_we = 1'b1;
                                if (w_ent.sent == '0) begin
                                    w_wdata.first_time = i_q_item.time_us;
                                    w_wdata.first_pkt  = i_q_item.pkt_num;
                                end
                                w_wdata.last_time = i_q_item.time_us;
                                w_wdata.last_pkt  = i_q_item.pkt_num;
                                w_wdata.sent      = mit_pkg::sat_add(w_ent.sent,
                                                                     i_q_item.byte_count);
                            end
                        end
                        mit_pkg::OP_BEGIN: begin
                            n_evrtt = i_q_item.rtt_us;
                            if (r_count != '0) n_state = mit_pkg::S_WALK;
                        end
                        mit_pkg::OP_LOST, mit_pkg::OP_ACKED: begin
                            if (r_count != '0) n_state = mit_pkg::S_WALK;
                        end
                        mit_pkg::OP_END: begin
                            if (r_ucount != '0) n_state = mit_pkg::S_WALK;
                        end
                        mit_pkg::OP_CLEAR: begin
                            n_count  = '0;
                            n_ucount = '0;
                            n_head   = '0;
                        end
                        default: ;
                    endcase
                end
            end

            // one interval per cycle
            mit_pkg::S_WALK: begin
                if (w_lastit) begin
                    n_state = mit_pkg::S_RESP;
                end else begin
                    n_idx = w_idx1;
                end
                case (r_item.op)
                    mit_pkg::OP_BEGIN: begin
                        w_dwe  = 1'b1;
                        w_dval = mit_pkg::is_complete(w_ent);
                    end
                    mit_pkg::OP_LOST, mit_pkg::OP_ACKED: begin
                        if (w_ent.useful && !w_done && r_item.pkt_num >= w_ent.first_pkt
                            && r_item.pkt_num <= w_ent.last_pkt) begin
                            w_we = 1'b1;
                            if (r_item.op == mit_pkg::OP_LOST) begin
                                w_wdata.lost = mit_pkg::sat_add(w_ent.lost, r_item.byte_count);
                            end else begin
                                if (w_ent.acked == '0) w_wdata.rtt_start = r_evrtt;
                                w_wdata.acked = mit_pkg::sat_add(w_ent.acked,
                                                                 r_item.byte_count);
                            end
                        end
                    end
                    mit_pkg::OP_END: begin
                        if (w_ent.useful) n_lastpos = w_idx1;
                        if (w_ent.useful && !w_done && !r_stop) begin
                            if (mit_pkg::is_complete(w_ent)) begin
                                w_we            = 1'b1;
                                w_wdata.rtt_end = r_evrtt;
                                w_dwe           = 1'b1;
                                w_dval          = 1'b1;
                                if (w_ent.first_time == w_ent.last_time) n_stop = 1'b1;
                            end else begin
                                n_notdone = 1'b1;
                            end
                        end
                        // settle the event on the last interval
                        if (w_lastit) begin
                            w_pop_lp = n_lastpos;
                            if (n_stop) begin
                                n_status = mit_pkg::ST_INVALID;
                                n_head   = w_phead;
                                n_count  = r_count - n_lastpos;
                                n_ucount = '0;
                            end else if (!n_notdone) begin
                                n_state = mit_pkg::S_EMIT;
                                n_idx   = '0;
                                n_keep  = r_count - n_lastpos;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            // one record per useful interval, then pop
            mit_pkg::S_EMIT: begin
                if (!w_ent.useful || w_ofree) begin
                    if (w_ent.useful) begin
                        w_load           = 1'b1;
                        n_out.status     = mit_pkg::ST_RECORD;
                        n_out.rate       = w_ent.rate;
                        n_out.tolerance  = w_ent.tolerance;
                        n_out.first_time = w_ent.first_time;
                        n_out.last_time  = w_ent.last_time;
                        n_out.sent       = w_ent.sent;
                        n_out.acked      = w_ent.acked;
                        n_out.lost       = w_ent.lost;
                        n_out.rtt_start  = w_ent.rtt_start;
                        n_out.rtt_end    = w_ent.rtt_end;
                        n_out.last       = (w_idx1 == r_lastpos);
                        n_out.occupancy  = w_occ_keep[mit_pkg::OCC_W-1:0];
                    end
                    if (w_idx1 == r_lastpos) begin
                        n_head   = w_phead;
                        n_count  = r_count - r_lastpos;
                        n_ucount = '0;
                        n_state  = mit_pkg::S_IDLE;
                    end else begin
                        n_idx = w_idx1;
                    end
                end
            end

            // single result beat
            mit_pkg::S_RESP: begin
                if (w_ofree) begin
                    w_load          = 1'b1;
                    n_out           = '0;
                    n_out.status    = r_status;
                    n_out.last      = 1'b1;
                    n_out.occupancy = w_occ_cnt[mit_pkg::OCC_W-1:0];
                    n_state         = mit_pkg::S_IDLE;
                end
            end

            default: n_state = mit_pkg::S_IDLE;
        endcase
    end

    // interval storage
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_ent[w_slot] <= w_wdata;
        end
    end

    // done marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (w_dwe) begin
            r_done[w_slot] <= w_dval;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mit_pkg::S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_ucount  <= '0;
            r_evrtt   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_ucount  <= n_ucount;
            r_evrtt   <= n_evrtt;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_status  <= n_status;
        r_idx     <= n_idx;
        r_lastpos <= n_lastpos;
        r_keep    <= n_keep;
        r_stop    <= n_stop;
        r_notdone <= n_notdone;
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_result    = r_out;

    // checks
    `MIT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(QUEUE_DEPTH), "interval count beyond queue depth")
    `MIT_ASSERT_IMP(a_useful_bound, i_clk, i_rst_n, 1'b1,
        r_ucount <= r_count, "useful count beyond interval count")
    `MIT_ASSERT_IMP(a_emit_has_useful, i_clk, i_rst_n, r_state == mit_pkg::S_EMIT,
        r_ucount != '0 && r_lastpos != '0, "record emission with no useful interval")
    `MIT_ASSERT_NXT(a_pop_only_idle, i_clk, i_rst_n, o_q_pop,
        r_state != mit_pkg::S_IDLE, "sequencer stayed idle after taking a beat")

endmodule

@@ tb/monitor_interval_tracker_test.sv @@
// ----------------------------------------------------------------------------
// monitor_interval_tracker_test
// Drives command beats into the interval tracker with random gaps and output
// stalls, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module monitor_interval_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = 16;
    localparam int WD_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_cmd = '0;
    logic [39:0] i_rate = '0;
    logic        i_useful = 1'b0;
    logic [15:0] i_tolerance = '0;
    logic [31:0] i_rtt_us = '0;
    logic [47:0] i_time_us = '0;
    logic [47:0] i_pkt_num = '0;
    logic [15:0] i_byte_count = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [39:0] o_rec_rate;
    logic [15:0] o_rec_tolerance;
    logic [47:0] o_rec_first_time, o_rec_last_time;
    logic [31:0] o_rec_sent, o_rec_acked, o_rec_lost, o_rec_rtt_start, o_rec_rtt_end;
    logic        o_last;
    logic [4:0]  o_occupancy;

    monitor_interval_tracker dut (.*);

    always #2ns i_clk = ~i_clk;

    // predictor state
    mit_pkg::t_entry ivl [DEPTH];
    logic            done_mark [DEPTH];
    int unsigned     head, count, nuseful;
    logic [31:0]     ev_rtt;

    mit_pkg::t_item   beat_q [$];
    mit_pkg::t_result result_q [$];
    int      errors = 0;
    bit      stim_done = 1'b0;
    int      idle_cycles = 0;
    int      in_gap = 0, out_gap = 0;

    // accept flags sampled at the rising edge for the driver
    logic o_in_stall_q = 1'b1;
    logic o_out_valid_q = 1'b0;

    function automatic void add_beat(mit_pkg::t_item b);
        beat_q.insert(beat_q.size(), b);
    endfunction

    function automatic void add_result(mit_pkg::t_result r);
        result_q.insert(result_q.size(), r);
    endfunction

    function automatic int unsigned slot(int unsigned i);
        return (head + i) % DEPTH;
    endfunction

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic filled(int unsigned s);
        return ({1'b0, ivl[s].acked} + {1'b0, ivl[s].lost}) == {1'b0, ivl[s].sent};
    endfunction

    function automatic mit_pkg::t_result plain(mit_pkg::t_status st);
        mit_pkg::t_result r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        r.occupancy = count[4:0];
        return r;
    endfunction

    task automatic drop_through_last_useful();
        while (nuseful > 0 && count > 0) begin
            if (ivl[head].useful) nuseful--;
            head = (head + 1) % DEPTH;
            count--;
        end
    endtask

    // compute expected results of one accepted beat
    task automatic predict_beat(mit_pkg::t_item b);
        int unsigned s, tot, n, keep, u;
        logic bad, all_fin;
        mit_pkg::t_result r;
        case (b.op)
            mit_pkg::OP_ENQ: begin
                if (count >= DEPTH) begin
                    add_result(plain(mit_pkg::ST_FULL));
                    return;
                end
                s = slot(count);
                ivl[s] = '0;
                ivl[s].rate = b.rate;
                ivl[s].useful = b.useful;
                ivl[s].tolerance = b.tolerance;
                ivl[s].rtt_start = b.rtt_us;
                ivl[s].rtt_end = b.rtt_us;
                done_mark[s] = 1'b0;
                count++;
                if (b.useful) nuseful++;
            end
            mit_pkg::OP_SENT: begin
                if (count == 0) begin
                    add_result(plain(mit_pkg::ST_EMPTY));
                    return;
                end
                s = slot(count - 1);
                if (ivl[s].sent == 0) begin
                    ivl[s].first_time = b.time_us;
                    ivl[s].first_pkt = b.pkt_num;
                end
                ivl[s].last_time = b.time_us;
                ivl[s].last_pkt = b.pkt_num;
                ivl[s].sent = add_sat(ivl[s].sent, b.byte_count);
            end
            mit_pkg::OP_BEGIN: begin
                ev_rtt = b.rtt_us;
                for (int unsigned i = 0; i < count; i++) done_mark[slot(i)] = filled(slot(i));
            end
            mit_pkg::OP_LOST, mit_pkg::OP_ACKED: begin
                for (int unsigned i = 0; i < count; i++) begin
                    s = slot(i);
                    if (!ivl[s].useful || done_mark[s]) continue;
                    if (b.pkt_num < ivl[s].first_pkt || b.pkt_num > ivl[s].last_pkt) continue;
                    if (b.op == mit_pkg::OP_LOST) begin
                        ivl[s].lost = add_sat(ivl[s].lost, b.byte_count);
                    end else begin
                        if (ivl[s].acked == 0) ivl[s].rtt_start = ev_rtt;
                        ivl[s].acked = add_sat(ivl[s].acked, b.byte_count);
                    end
                end
            end
            mit_pkg::OP_END: begin
                if (nuseful == 0) begin
                    add_result(plain(mit_pkg::ST_OK));
                    return;
                end
                bad = 1'b0;
                for (int unsigned i = 0; i < count; i++) begin
                    s = slot(i);
                    if (!ivl[s].useful || done_mark[s]) continue;
                    if (filled(s)) begin
                        ivl[s].rtt_end = ev_rtt;
                        done_mark[s] = 1'b1;
                        if (ivl[s].first_time == ivl[s].last_time) begin
                            bad = 1'b1;
                            break;
                        end
                    end
                end
                if (bad) begin
                    drop_through_last_useful();
                    add_result(plain(mit_pkg::ST_INVALID));
                    return;
                end
                all_fin = 1'b1;
                for (int unsigned i = 0; i < count; i++) begin
                    s = slot(i);
                    if (ivl[s].useful && !done_mark[s] && !filled(s)) all_fin = 1'b0;
                end
                if (!all_fin) begin
                    add_result(plain(mit_pkg::ST_OK));
                    return;
                end
                tot = 0;
                for (int unsigned i = 0; i < count; i++) if (ivl[slot(i)].useful) tot++;
                keep = count;
                u = nuseful;
                for (int unsigned i = 0; i < count && u > 0; i++) begin
                    if (ivl[slot(i)].useful) u--;
                    keep--;
                end
                n = 0;
                for (int unsigned i = 0; i < count; i++) begin
                    s = slot(i);
                    if (!ivl[s].useful) continue;
                    r = '0;
                    r.status = mit_pkg::ST_RECORD;
                    r.rate = ivl[s].rate;
                    r.tolerance = ivl[s].tolerance;
                    r.first_time = ivl[s].first_time;
                    r.last_time = ivl[s].last_time;
                    r.sent = ivl[s].sent;
                    r.acked = ivl[s].acked;
                    r.lost = ivl[s].lost;
                    r.rtt_start = ivl[s].rtt_start;
                    r.rtt_end = ivl[s].rtt_end;
                    n++;
                    r.last = (n == tot);
                    r.occupancy = keep[4:0];
                    add_result(r);
                end
                drop_through_last_useful();
                return;
            end
            mit_pkg::OP_CLEAR: begin
                count = 0;
                nuseful = 0;
                head = 0;
            end
            default: ;
        endcase
        add_result(plain(mit_pkg::ST_OK));
    endtask

    function automatic mit_pkg::t_item mk(mit_pkg::t_op op);
        mit_pkg::t_item b;
        b = '0;
        b.op = op;
        return b;
    endfunction

    function automatic mit_pkg::t_item rnd_item();
        mit_pkg::t_item b;
        b.op = mit_pkg::t_op'(3'($urandom_range(7)));
        b.rate = 40'({$urandom, $urandom});
        b.useful = 1'($urandom_range(1));
        b.tolerance = 16'($urandom);
        b.rtt_us = $urandom;
        b.time_us = 48'({$urandom, $urandom});
        b.pkt_num = 48'({$urandom, $urandom});
        b.byte_count = 16'($urandom);
        return b;
    endfunction

    // one well-formed interval round: enqueue, send, event, end
    task automatic add_round();
        mit_pkg::t_item b;
        int nint, npk;
        logic [47:0] pk, t;
        logic [47:0] lo [$];
        logic [15:0] by [$];
        nint = $urandom_range(1, 4);
        pk = 48'($urandom_range(1000));
        t = 48'($urandom_range(1000));
        for (int k = 0; k < nint; k++) begin
            b = rnd_item();
            b.op = mit_pkg::OP_ENQ;
            b.useful = ($urandom_range(3) != 0);
            add_beat(b);
            npk = $urandom_range(1, 3);
            for (int p = 0; p < npk; p++) begin
                b = rnd_item();
                b.op = mit_pkg::OP_SENT;
                b.pkt_num = pk;
                b.time_us = ($urandom_range(9) == 0) ? t : t + 48'(p);
                b.byte_count = 16'($urandom_range(1, 1500));
                by.insert(by.size(), b.byte_count);
                lo.insert(lo.size(), pk);
                pk++;
                add_beat(b);
            end
            t += 48'd10;
        end
        b = rnd_item();
        b.op = mit_pkg::OP_BEGIN;
        add_beat(b);
        foreach (lo[j]) begin
            if ($urandom_range(9) == 0) continue;
            b = rnd_item();
            b.op = ($urandom_range(3) == 0) ? mit_pkg::OP_LOST : mit_pkg::OP_ACKED;
            b.pkt_num = lo[j];
            b.byte_count = by[j];
            add_beat(b);
        end
        b = rnd_item();
        b.op = mit_pkg::OP_END;
        add_beat(b);
    endtask

    // driver
    always @(negedge i_clk) begin
        int d;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall_q) begin
                // beat accepted at last rising edge
                if (beat_q.size() > 0) beat_q.delete(0);
                in_gap <= $urandom_range(11);
                i_in_valid <= 1'b0;
            end else if (!i_in_valid) begin
                if (in_gap > 0) in_gap <= in_gap - 1;
                else if (beat_q.size() > 0) begin
                    i_cmd <= beat_q[0].op;
                    i_rate <= beat_q[0].rate;
                    i_useful <= beat_q[0].useful;
                    i_tolerance <= beat_q[0].tolerance;
                    i_rtt_us <= beat_q[0].rtt_us;
                    i_time_us <= beat_q[0].time_us;
                    i_pkt_num <= beat_q[0].pkt_num;
                    i_byte_count <= beat_q[0].byte_count;
                    i_in_valid <= 1'b1;
                end
            end
            // output side: new stall length after each accepted result beat
            if (o_out_valid_q && !i_out_stall) begin
                d = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(11));
                i_out_stall <= (d != 0);
                out_gap <= (d > 0) ? d - 1 : 0;
            end else if (out_gap > 0) begin
                i_out_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        mit_pkg::t_item b;
        mit_pkg::t_result e;
        bit moved;
        if (i_rst_n) begin
            moved = 1'b0;
            o_in_stall_q <= o_in_stall;
            o_out_valid_q <= o_out_valid;
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                b.op = mit_pkg::t_op'(i_cmd);
                b.rate = i_rate;
                b.useful = i_useful;
                b.tolerance = i_tolerance;
                b.rtt_us = i_rtt_us;
                b.time_us = i_time_us;
                b.pkt_num = i_pkt_num;
                b.byte_count = i_byte_count;
                predict_beat(b);
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected, status %0d", o_status);
                    errors++;
                end else begin
                    e = result_q[0];
                    result_q.delete(0);
                    if (o_status != e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status); errors++; end
                    if (o_rec_rate != e.rate) begin
                        $error("rec_rate exp %0h got %0h", e.rate, o_rec_rate); errors++; end
                    if (o_rec_tolerance != e.tolerance) begin
                        $error("rec_tolerance exp %0h got %0h", e.tolerance, o_rec_tolerance);
                        errors++; end
                    if (o_rec_first_time != e.first_time) begin
                        $error("rec_first_time exp %0h got %0h", e.first_time,
                               o_rec_first_time); errors++; end
                    if (o_rec_last_time != e.last_time) begin
                        $error("rec_last_time exp %0h got %0h", e.last_time, o_rec_last_time);
                        errors++; end
                    if (o_rec_sent != e.sent) begin
                        $error("rec_sent exp %0h got %0h", e.sent, o_rec_sent); errors++; end
                    if (o_rec_acked != e.acked) begin
                        $error("rec_acked exp %0h got %0h", e.acked, o_rec_acked); errors++; end
                    if (o_rec_lost != e.lost) begin
                        $error("rec_lost exp %0h got %0h", e.lost, o_rec_lost); errors++; end
                    if (o_rec_rtt_start != e.rtt_start) begin
                        $error("rec_rtt_start exp %0h got %0h", e.rtt_start, o_rec_rtt_start);
                        errors++; end
                    if (o_rec_rtt_end != e.rtt_end) begin
                        $error("rec_rtt_end exp %0h got %0h", e.rtt_end, o_rec_rtt_end);
                        errors++; end
                    if (o_last != e.last) begin
                        $error("last exp %0d got %0d", e.last, o_last); errors++; end
                    if (o_occupancy != e.occupancy) begin
                        $error("occupancy exp %0d got %0d", e.occupancy, o_occupancy);
                        errors++; end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("monitor_interval_tracker_test failed");
                $finish;
            end
        end
    end

    initial begin
        mit_pkg::t_item b;
        head = 0; count = 0; nuseful = 0; ev_rtt = '0;
        foreach (done_mark[k]) done_mark[k] = 1'b0;
        // directed: empty-queue send, empty end, unused op, extremes, overflow
        add_beat(mk(mit_pkg::OP_SENT));
        add_beat(mk(mit_pkg::OP_END));
        add_beat(mk(mit_pkg::OP_NONE));
        add_beat(mk(mit_pkg::OP_LOST));
        b = '1;
        b.op = mit_pkg::OP_ENQ;
        add_beat(b);
        b.op = mit_pkg::OP_SENT;
        b.time_us = '0;
        add_beat(b);
        b.op = mit_pkg::OP_SENT;
        b.time_us = '1;
        add_beat(b);
        b.op = mit_pkg::OP_BEGIN;
        add_beat(b);
        b.op = mit_pkg::OP_ACKED;
        b.byte_count = 16'd0;
        add_beat(b);
        b.op = mit_pkg::OP_ACKED;
        b.byte_count = 16'hFFFE;
        add_beat(b);
        b.op = mit_pkg::OP_LOST;
        b.byte_count = 16'hFFFF;
        add_beat(b);
        b.op = mit_pkg::OP_END;
        add_beat(b);
        // invalid interval: single send time
        b = mk(mit_pkg::OP_ENQ); b.useful = 1'b1; add_beat(b);
        b = mk(mit_pkg::OP_SENT); b.byte_count = 16'd5; b.pkt_num = 48'd3; add_beat(b);
        add_beat(mk(mit_pkg::OP_BEGIN));
        b = mk(mit_pkg::OP_ACKED); b.byte_count = 16'd5; b.pkt_num = 48'd3; add_beat(b);
        add_beat(mk(mit_pkg::OP_END));
        for (int k = 0; k < DEPTH + 1; k++) add_beat(mk(mit_pkg::OP_ENQ));
        add_beat(mk(mit_pkg::OP_CLEAR));
        // random: mostly well-formed rounds, some noise
        while (beat_q.size() < 360) begin
            if ($urandom_range(4) == 0) begin
                for (int k = $urandom_range(1, 4); k > 0; k--) add_beat(rnd_item());
            end else add_round();
            if ($urandom_range(9) == 0) add_beat(mk(mit_pkg::OP_CLEAR));
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (beat_q.size() == 0 && !i_in_valid);
        wait (result_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("monitor_interval_tracker_test passed");
        end else begin
            $display("monitor_interval_tracker_test failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+sv
sv/mit_pkg.sv
sv/mit_front.sv
sv/mit_back.sv
sv/monitor_interval_tracker.sv
tb/monitor_interval_tracker_test.sv
